### hdl/vats_pkg.sv
package vats_pkg;

    // Command codes
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_ABORT = 3'd1;
    localparam logic [2:0] CMD_SYNC  = 3'd2;
    localparam logic [2:0] CMD_TICK  = 3'd3;
    localparam logic [2:0] CMD_LIMIT = 3'd4;

    // Reply codes
    localparam logic [1:0] RP_NONE = 2'd0;
    localparam logic [1:0] RP_OK   = 2'd1;
    localparam logic [1:0] RP_FAIL = 2'd2;

    // Valve motor drive codes
    localparam logic [1:0] VM_STOP  = 2'd0;
    localparam logic [1:0] VM_OPEN  = 2'd1;
    localparam logic [1:0] VM_CLOSE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_OPEN_TIME     = 2'd0;
    localparam logic [1:0] REG_CLOSE_TIME    = 2'd1;
    localparam logic [1:0] REG_TRANSFER_TIME = 2'd2;

    localparam int unsigned TIMER_W       = 26;
    localparam int unsigned CFG_W         = 16;
    localparam logic [9:0]  TICKS_PER_S   = 10'd1000;
    localparam logic [1:0]  SYNC_EXTRA_MS = 2'd2;

    typedef struct packed {
        logic [2:0] command;
        logic       valve_closed;
    } t_in;

    typedef struct packed {
        logic [1:0] reply;
        logic       auger_run;
        logic [1:0] valve_drive;
        logic [2:0] phase_now;
    } t_out;

    // Timer durations as loaded on a timer start
    typedef struct packed {
        logic [CFG_W-1:0]   open_ms;
        logic [CFG_W-1:0]   close_ms;
        logic [TIMER_W-1:0] transfer_ticks;
    } t_cfg;

endpackage

### hdl/vats_cfg.sv
module vats_cfg
    import vats_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    logic [CFG_W-1:0]   r_open_ms;
    logic [CFG_W-1:0]   r_close_ms;
    logic [TIMER_W-1:0] r_transfer_ticks;
    logic [TIMER_W-1:0] n_transfer_ticks;

    // Scale seconds to ms ticks at write time, off the step path
    assign n_transfer_ticks = TIMER_W'(i_cfg_data) * TIMER_W'(TICKS_PER_S);

    // Hold register values, update on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_ms        <= '0;
            r_close_ms       <= '0;
            r_transfer_ticks <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OPEN_TIME:     r_open_ms        <= i_cfg_data;
                REG_CLOSE_TIME:    r_close_ms       <= i_cfg_data;
                REG_TRANSFER_TIME: r_transfer_ticks <= n_transfer_ticks;
                default: ;
            endcase
        end
    end

    assign o_cfg.open_ms        = r_open_ms;
    assign o_cfg.close_ms       = r_close_ms;
    assign o_cfg.transfer_ticks = r_transfer_ticks;

endmodule

### hdl/vats_core.sv
module vats_core
    import vats_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_go,
    input  t_in  i_cmd,
    input  t_cfg i_cfg,
    output t_out o_res
);

    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_OPENING      = 3'd1,
        PH_TRANSFERRING = 3'd2,
        PH_CLOSING      = 3'd3,
        PH_SYNCING      = 3'd4
    } t_phase;

    t_phase             r_phase,    n_phase;
    logic [TIMER_W-1:0] r_ticks,    n_ticks;
    logic               r_timer_on, n_timer_on;
    logic               r_auger_on, n_auger_on;
    logic [1:0]         r_valve,    n_valve;
    logic [1:0]         w_reply;
    logic [TIMER_W-1:0] w_sync_ticks;

    assign w_sync_ticks = TIMER_W'(i_cfg.open_ms) + TIMER_W'(SYNC_EXTRA_MS);

    // Decide the next phase, timer and drives for the transaction at hand
    always_comb begin
        n_phase    = r_phase;
        n_ticks    = r_ticks;
        n_timer_on = r_timer_on;
        n_auger_on = r_auger_on;
        n_valve    = r_valve;
        w_reply    = RP_NONE;
        case (i_cmd.command)
            CMD_START: begin
                if (r_phase == PH_IDLE) begin
                    n_phase    = PH_OPENING;
                    w_reply    = RP_OK;
                    n_ticks    = TIMER_W'(i_cfg.open_ms);
                    n_timer_on = 1'b1;
                    n_valve    = VM_OPEN;
                end else if (r_phase == PH_SYNCING) begin
                    w_reply = RP_FAIL;
                end else begin
                    w_reply = RP_OK;
                end
            end
            CMD_ABORT: begin
                if (r_phase == PH_IDLE) begin
                    w_reply = RP_OK;
                end else if (r_phase == PH_TRANSFERRING) begin
                    n_timer_on = 1'b0;
                    n_valve    = VM_STOP;
                    n_auger_on = 1'b0;
                    n_phase    = PH_IDLE;
                    w_reply    = RP_OK;
                end else if (r_phase == PH_OPENING || r_phase == PH_CLOSING) begin
                    w_reply = RP_FAIL;
                end
            end
            CMD_SYNC: begin
                if (r_phase == PH_IDLE) begin
                    w_reply = RP_OK;
                    if (!i_cmd.valve_closed) begin
                        n_phase    = PH_SYNCING;
                        n_valve    = VM_CLOSE;
                        n_ticks    = w_sync_ticks;
                        n_timer_on = 1'b1;
                    end
                end else begin
                    w_reply = RP_FAIL;
                end
            end
            CMD_TICK: begin
                if (r_timer_on) begin
                    if (r_ticks <= TIMER_W'(1)) begin
                        // Expire: act on the current phase
                        n_ticks    = '0;
                        n_timer_on = 1'b0;
                        case (r_phase)
                            PH_OPENING: begin
                                n_valve    = VM_STOP;
                                n_phase    = PH_TRANSFERRING;
                                n_ticks    = i_cfg.transfer_ticks;
                                n_timer_on = 1'b1;
                                n_auger_on = 1'b1;
                            end
                            PH_TRANSFERRING: begin
                                n_auger_on = 1'b0;
                                n_phase    = PH_CLOSING;
                                n_ticks    = TIMER_W'(i_cfg.close_ms);
                                n_timer_on = 1'b1;
                                n_valve    = VM_CLOSE;
                            end
                            PH_CLOSING, PH_SYNCING: begin
                                n_valve = VM_STOP;
                                n_phase = PH_IDLE;
                            end
                            default: ;
                        endcase
                    end else begin
                        n_ticks = r_ticks - TIMER_W'(1);
                    end
                end
            end
            CMD_LIMIT: begin
                n_valve = VM_STOP;
            end
            default: ;
        endcase
    end

    // Hold sequencer state, advance on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_ticks    <= '0;
            r_timer_on <= 1'b0;
            r_auger_on <= 1'b0;
            r_valve    <= VM_STOP;
        end else if (i_go) begin
            r_phase    <= n_phase;
            r_ticks    <= n_ticks;
            r_timer_on <= n_timer_on;
            r_auger_on <= n_auger_on;
            r_valve    <= n_valve;
        end
    end

    assign o_res.reply       = w_reply;
    assign o_res.auger_run   = n_auger_on;
    assign o_res.valve_drive = n_valve;
    assign o_res.phase_now   = n_phase;

`ifndef SYNTH
    a_idle_timer_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> !r_timer_on)
        else $error("timer running while idle");

    a_auger_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_auger_on == (r_phase == PH_TRANSFERRING))
        else $error("auger drive out of step with phase");

    a_valve_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valve != 2'd3)
        else $error("illegal valve drive code");
`endif

endmodule

### hdl/valve_auger_transfer_sequencer.sv
// A command is captured in the input register, then the sequencer step loads
// its result into the result register; a stalled result register holds it back.
// Throughput: one transaction per cycle while the result channel does not stall;
// the phase and timer update in the single step between the two registers.
// Reset: synchronous, active low; phase idle, timer stopped, both motors off,
// timing registers zero.
module valve_auger_transfer_sequencer
    import vats_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in              i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out             o_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;
    logic w_advance;
    t_cfg w_cfg;
    t_out w_res;

    vats_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    vats_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_advance),
        .i_cmd   (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Step when a command waits and the result register is free or drains
    assign w_advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_data;
        end
    end

    // Result register: load on step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall))
        else $error("input stalled while result register can take a transaction");
`endif

endmodule

### tb/valve_auger_transfer_sequencer_tb.sv
module valve_auger_transfer_sequencer_tb;
    import vats_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_OPENING      = 3'd1,
        PH_TRANSFERRING = 3'd2,
        PH_CLOSING      = 3'd3,
        PH_SYNCING      = 3'd4
    } t_phase;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    // Command codes the sequencer must ignore
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam int          SETTLE_CYCLES  = 3;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          RANDOM_PER_SET = 70;
    localparam int          RANDOM_SETS    = 4;
    localparam logic [15:0] TIME_MAX       = 16'hFFFF;
    localparam logic [15:0] SYNC_RUN_MS    = 16'd40;
    localparam logic [15:0] CLOSE_RUN_MS   = 16'd50;

    typedef struct {
        bit               is_write;
        logic [1:0]       reg_idx;
        logic [CFG_W-1:0] reg_val;
        logic [2:0]       command;
        logic             valve_closed;
        bit               typed;
        t_out             want;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    t_in              i_data;
    logic             o_valid;
    logic             i_stall;
    t_out             o_data;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    // Timing registers as the sequencer should hold them
    logic [CFG_W-1:0]   cfg_open_ms;
    logic [CFG_W-1:0]   cfg_close_ms;
    logic [CFG_W-1:0]   cfg_xfer_s;

    // Sequencer state as predicted
    t_phase             seq_phase;
    logic [TIMER_W-1:0] seq_ticks;
    logic               seq_timer_on;
    logic               seq_auger;
    logic [1:0]         seq_valve;

    t_out drives_due_q[$];
    t_row script_rows[$];

    int n_sent      = 0;
    int n_directed  = 0;
    int n_results   = 0;
    int n_errors    = 0;
    int n_transfers = 0;
    int n_syncs     = 0;
    bit fast_mode   = 1'b0;
    int burst_left  = 0;

    valve_auger_transfer_sequencer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Load the one-shot timer
    function automatic void arm_timer(input logic [TIMER_W-1:0] ticks);
        seq_ticks    = ticks;
        seq_timer_on = 1'b1;
    endfunction

    // Advance the predicted sequencer by one command and return its drives
    task automatic advance_sequencer(input t_in item, output t_out res);
        logic [TIMER_W-1:0] ticks;
        logic [1:0]         reply;
        reply = RP_NONE;
        case (item.command)
            CMD_START: begin
                if (seq_phase == PH_IDLE) begin
                    seq_phase = PH_OPENING;
                    reply     = RP_OK;
                    arm_timer(TIMER_W'(cfg_open_ms));
                    seq_valve = VM_OPEN;
                end else if (seq_phase == PH_SYNCING) begin
                    reply = RP_FAIL;
                end else begin
                    reply = RP_OK;
                end
            end
            CMD_ABORT: begin
                if (seq_phase == PH_IDLE) begin
                    reply = RP_OK;
                end else if (seq_phase == PH_TRANSFERRING) begin
                    seq_timer_on = 1'b0;
                    seq_valve    = VM_STOP;
                    seq_auger    = 1'b0;
                    seq_phase    = PH_IDLE;
                    reply        = RP_OK;
                end else if (seq_phase == PH_OPENING || seq_phase == PH_CLOSING) begin
                    reply = RP_FAIL;
                end
            end
            CMD_SYNC: begin
                if (seq_phase == PH_IDLE) begin
                    reply = RP_OK;
                    if (!item.valve_closed) begin
                        seq_phase = PH_SYNCING;
                        seq_valve = VM_CLOSE;
                        ticks     = TIMER_W'(cfg_open_ms);
                        arm_timer(ticks + TIMER_W'(SYNC_EXTRA_MS));
                    end
                end else begin
                    reply = RP_FAIL;
                end
            end
            CMD_TICK: begin
                if (seq_timer_on) begin
                    if (seq_ticks <= 1) begin
                        // Expire the timer and move to the next phase
                        seq_ticks    = '0;
                        seq_timer_on = 1'b0;
                        case (seq_phase)
                            PH_OPENING: begin
                                seq_valve = VM_STOP;
                                seq_phase = PH_TRANSFERRING;
                                ticks     = TIMER_W'(cfg_xfer_s);
                                arm_timer(ticks * TIMER_W'(TICKS_PER_S));
                                seq_auger = 1'b1;
                            end
                            PH_TRANSFERRING: begin
                                seq_auger = 1'b0;
                                seq_phase = PH_CLOSING;
                                arm_timer(TIMER_W'(cfg_close_ms));
                                seq_valve = VM_CLOSE;
                            end
                            PH_CLOSING: begin
                                seq_valve = VM_STOP;
                                seq_phase = PH_IDLE;
                                n_transfers++;
                            end
                            PH_SYNCING: begin
                                seq_valve = VM_STOP;
                                seq_phase = PH_IDLE;
                                n_syncs++;
                            end
                            default: ;
                        endcase
                    end else begin
                        seq_ticks = seq_ticks - 1'b1;
                    end
                end
            end
            CMD_LIMIT: seq_valve = VM_STOP;
            default: ;
        endcase
        res.reply       = reply;
        res.auger_run   = seq_auger;
        res.valve_drive = seq_valve;
        res.phase_now   = seq_phase;
    endtask

    // Drive one command transaction; entered and left just after a falling edge
    task automatic send_cmd(input logic [2:0] command, input logic vc,
                            input bit typed = 1'b0, input t_out want = '0);
        t_in  item;
        t_out predicted;
        int   gap;
        item.command      = command;
        item.valve_closed = vc;
        gap = 0;
        if (!fast_mode) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        if (gap != 0) begin
            // drop valid for the gap between bursts
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        advance_sequencer(item, predicted);
        drives_due_q.push_back(typed ? want : predicted);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every expected result has come back
    task automatic wait_results_done();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (drives_due_q.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_OPEN_TIME:     cfg_open_ms  = val;
            REG_CLOSE_TIME:    cfg_close_ms = val;
            REG_TRANSFER_TIME: cfg_xfer_s   = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] open_ms,
                              input logic [CFG_W-1:0] close_ms,
                              input logic [CFG_W-1:0] xfer_s);
        write_reg(REG_OPEN_TIME, open_ms);
        write_reg(REG_CLOSE_TIME, close_ms);
        write_reg(REG_TRANSFER_TIME, xfer_s);
    endtask

    // Feed millisecond ticks until the predicted phase is reached
    task automatic tick_until(input t_phase target);
        while (seq_phase != target) send_cmd(CMD_TICK, 1'($urandom_range(0, 1)));
    endtask

    // Favor starts and syncs from idle, ticks while a sequence runs
    function automatic logic [2:0] pick_command();
        int roll;
        roll = $urandom_range(0, 99);
        if (seq_phase == PH_IDLE) begin
            if (roll < 30) return CMD_START;
            if (roll < 45) return CMD_SYNC;
            if (roll < 52) return CMD_ABORT;
            if (roll < 58) return CMD_LIMIT;
            if (roll < 90) return CMD_TICK;
        end else begin
            if (roll < 6) return CMD_START;
            if (roll < 14) return CMD_ABORT;
            if (roll < 20) return CMD_SYNC;
            if (roll < 26) return CMD_LIMIT;
            if (roll < 96) return CMD_TICK;
        end
        return 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    endfunction

    function automatic void add_cmd(input logic [2:0] command, input logic vc);
        t_row row;
        row              = '{default: '0};
        row.command      = command;
        row.valve_closed = vc;
        script_rows.push_back(row);
    endfunction

    function automatic void add_typed(input logic [2:0] command, input logic vc,
                                      input logic [1:0] reply, input logic auger,
                                      input logic [1:0] valve, input t_phase phase);
        t_row row;
        row                  = '{default: '0};
        row.command          = command;
        row.valve_closed     = vc;
        row.typed            = 1'b1;
        row.want.reply       = reply;
        row.want.auger_run   = auger;
        row.want.valve_drive = valve;
        row.want.phase_now   = phase;
        script_rows.push_back(row);
    endfunction

    function automatic void add_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        t_row row;
        row          = '{default: '0};
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_val  = val;
        script_rows.push_back(row);
    endfunction

    task automatic check_field(input string field, input logic [2:0] want,
                               input logic [2:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            n_errors++;
        end
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (drives_due_q.size() == 0) begin
                $display("%0t: result with none expected: expected nothing, actual %p",
                         $time, o_data);
                n_errors++;
            end else begin
                want = drives_due_q.pop_front();
                check_field("reply", 3'(want.reply), 3'(o_data.reply));
                check_field("auger_run", 3'(want.auger_run), 3'(o_data.auger_run));
                check_field("valve_drive", 3'(want.valve_drive), 3'(o_data.valve_drive));
                check_field("phase_now", want.phase_now, o_data.phase_now);
            end
        end
    end

    // Stall the result channel on a pattern that is chosen anew at random
    initial begin : result_stall
        t_stall_mode mode;
        int          mode_left;
        int          beat;
        i_stall   = 1'b0;
        mode      = STALL_NONE;
        mode_left = 0;
        beat      = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            beat++;
            case (mode)
                STALL_NONE:     i_stall <= 1'b0;
                STALL_RANDOM:   i_stall <= ($urandom_range(0, 2) == 0);
                STALL_PERIODIC: i_stall <= (beat % 4 == 3);
                default:        i_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // End the run when no transaction moves for too long
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) stuck = 0;
            else stuck++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("valve_auger_transfer_sequencer regression: fail");
        $finish;
    end

    initial begin : stimulus
        int pause_at;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_OPEN_TIME;
        i_cfg_data   = '0;
        cfg_open_ms  = '0;
        cfg_close_ms = '0;
        cfg_xfer_s   = '0;
        seq_phase    = PH_IDLE;
        seq_ticks    = '0;
        seq_timer_on = 1'b0;
        seq_auger    = 1'b0;
        seq_valve    = VM_STOP;

        // Directed table: reset state, then commands in every phase
        add_typed(CMD_TICK, 1'b0, RP_NONE, 1'b0, VM_STOP, PH_IDLE);
        add_typed(CMD_ABORT, 1'b1, RP_OK, 1'b0, VM_STOP, PH_IDLE);
        add_typed(CMD_SPARE_HI, 1'b1, RP_NONE, 1'b0, VM_STOP, PH_IDLE);
        add_typed(CMD_LIMIT, 1'b0, RP_NONE, 1'b0, VM_STOP, PH_IDLE);
        add_typed(CMD_SYNC, 1'b1, RP_OK, 1'b0, VM_STOP, PH_IDLE);
        add_write(REG_OPEN_TIME, 16'd1);
        add_typed(CMD_START, 1'b0, RP_OK, 1'b0, VM_OPEN, PH_OPENING);
        add_cmd(CMD_START, 1'b1);
        add_typed(CMD_ABORT, 1'b0, RP_FAIL, 1'b0, VM_OPEN, PH_OPENING);
        add_cmd(CMD_SYNC, 1'b0);
        add_cmd(CMD_LIMIT, 1'b1);
        add_cmd(CMD_TICK, 1'b0);
        add_cmd(CMD_START, 1'b0);
        add_cmd(CMD_TICK, 1'b1);
        add_cmd(CMD_ABORT, 1'b1);
        add_cmd(CMD_TICK, 1'b0);
        add_cmd(CMD_START, 1'b1);
        add_cmd(CMD_TICK, 1'b1);
        add_typed(CMD_ABORT, 1'b0, RP_OK, 1'b0, VM_STOP, PH_IDLE);
        add_cmd(CMD_SYNC, 1'b0);
        add_cmd(CMD_START, 1'b1);
        add_cmd(CMD_ABORT, 1'b0);
        add_cmd(CMD_LIMIT, 1'b0);
        add_cmd(CMD_TICK, 1'b1);
        add_cmd(CMD_TICK, 1'b0);
        add_cmd(CMD_TICK, 1'b1);
        add_typed(CMD_SPARE_LO, 1'b0, RP_NONE, 1'b0, VM_STOP, PH_IDLE);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script_rows[r]) begin
            if (script_rows[r].is_write)
                write_reg(script_rows[r].reg_idx, script_rows[r].reg_val);
            else
                send_cmd(script_rows[r].command, script_rows[r].valve_closed,
                         script_rows[r].typed, script_rows[r].want);
        end
        n_directed = n_sent;

        // Longest transfer time: enter transferring, then abort
        set_timing('0, '0, TIME_MAX);
        send_cmd(CMD_START, 1'b0);
        send_cmd(CMD_TICK, 1'b1);
        repeat (3) send_cmd(CMD_TICK, 1'b0);
        send_cmd(CMD_ABORT, 1'b0);

        // Full sync run, ticked out to idle
        set_timing(SYNC_RUN_MS, CLOSE_RUN_MS, '0);
        send_cmd(CMD_SYNC, 1'b0);
        fast_mode = 1'b1;
        tick_until(PH_IDLE);
        fast_mode = 1'b0;

        // Full close run, with commands poked in while closing
        write_reg(REG_OPEN_TIME, '0);
        send_cmd(CMD_START, 1'b1);
        tick_until(PH_CLOSING);
        send_cmd(CMD_ABORT, 1'b0);
        send_cmd(CMD_START, 1'b0);
        send_cmd(CMD_SYNC, 1'b0);
        send_cmd(CMD_LIMIT, 1'b1);
        fast_mode = 1'b1;
        tick_until(PH_IDLE);
        fast_mode = 1'b0;

        // Random commands over several short timing settings
        for (int set_no = 0; set_no < RANDOM_SETS; set_no++) begin
            case (set_no)
                0: set_timing(16'd0, 16'd0, 16'd0);
                1: set_timing(16'd2, 16'd3, 16'd0);
                2: set_timing(16'd7, 16'd1, 16'd0);
                default: set_timing(16'($urandom_range(0, 9)), 16'($urandom_range(0, 9)),
                                    16'd0);
            endcase
            pause_at = $urandom_range(10, RANDOM_PER_SET - 10);
            for (int k = 0; k < RANDOM_PER_SET; k++) begin
                if (k == pause_at) wait_results_done();
                send_cmd(pick_command(), 1'($urandom_range(0, 1)));
            end
        end

        wait_results_done();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Sent %0d commands (%0d from the table), checked %0d results.",
                 n_sent, n_directed, n_results);
        $display("Completed %0d transfers and %0d syncs; maximum transfer time loaded once.",
                 n_transfers, n_syncs);
        if (n_errors == 0)
            $display("valve_auger_transfer_sequencer regression: pass");
        else
            $display("valve_auger_transfer_sequencer regression: fail");
        $finish;
    end

endmodule
